// ===== design/clf_pkg.sv =====
// shared constants, codes and types of the comment line filter
package clf_pkg;

   localparam int LINE_LIMIT    = 254;
   localparam int PENDING_DEPTH = 32;

   localparam int ADDR_W = $clog2(PENDING_DEPTH);
   localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
   localparam int LEN_W  = $clog2(LINE_LIMIT + 1);

   localparam logic [7:0] CH_NL   = 8'd10;
   localparam logic [7:0] CH_TAB  = 8'd9;
   localparam logic [7:0] CH_SP   = 8'd32;
   localparam logic [7:0] CH_HASH = 8'd35;
   localparam logic [7:0] CH_BSL  = 8'd92;

   typedef enum logic [1:0] {
      K_CHAR       = 2'd0,
      K_LINE_END   = 2'd1,
      K_STREAM_END = 2'd2,
      K_OVERFLOW   = 2'd3
   } clf_kind_type;

   typedef enum logic [1:0] {
      PH_LEAD = 2'd0,
      PH_BODY = 2'd1,
      PH_CUT  = 2'd2,
      PH_DROP = 2'd3
   } clf_phase_type;

   typedef enum logic [2:0] {
      E_IDLE,
      E_READ,
      E_FLUSH,
      E_TAIL0,
      E_TAIL1
   } clf_state_type;

   // what one accepted item has to put out: held bytes first, then up to two results
   typedef struct packed {
      logic [CNT_W-1:0] flush_cnt;
      logic             flush_bsl;
      logic [1:0]       tail_cnt;
      clf_kind_type     tail0_kind;
      logic [7:0]       tail0_char;
      clf_kind_type     tail1_kind;
   } clf_plan_type;

endpackage

// ===== design/clf_pend_ram.sv =====
// memory of held blank bytes, one write and one registered read port
module clf_pend_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [clf_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [clf_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [clf_pkg::PENDING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/clf_line_ctl.sv =====
// per-line state, option register and the decision for each accepted item
module clf_line_ctl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   input  logic                       take,
   input  logic                       act,
   input  logic [7:0]                 chr,
   output clf_pkg::clf_plan_type      plan,
   output logic                       mem_wr,
   output logic [clf_pkg::ADDR_W-1:0] mem_addr,
   output logic [7:0]                 mem_data
);

   logic                        strip_ff;
   logic [clf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        bsl_ff, bsl_in;
   clf_pkg::clf_phase_type      phase_ff, phase_in;
   logic                        has_ff, has_in;
   logic [clf_pkg::LEN_W-1:0]   len_ff, len_in;

   logic blank, is_hash, line_end, emit_le, too_long;
   logic want_hold, want_nb, drop_hash, to_cut, hold_full, err;

   // classify the item against the current line state
   always_comb begin
      blank     = (chr == clf_pkg::CH_SP) || (chr == clf_pkg::CH_TAB);
      is_hash   = (chr == clf_pkg::CH_HASH);
      line_end  = act || (chr == clf_pkg::CH_NL);
      emit_le   = !((cnt_ff != '0) && bsl_ff) && has_ff;
      too_long  = !line_end && (len_ff >= clf_pkg::LEN_W'(clf_pkg::LINE_LIMIT));
      want_hold = 1'b0;
      want_nb   = 1'b0;
      drop_hash = 1'b0;
      to_cut    = 1'b0;
      if (!line_end && !too_long) begin
         case (phase_ff)
            clf_pkg::PH_LEAD: begin
               if (blank) want_hold = 1'b1;
               else if (is_hash) drop_hash = 1'b1;
               else want_nb = 1'b1;
            end
            clf_pkg::PH_BODY: begin
               if (is_hash && strip_ff) to_cut = 1'b1;
               else if (blank) want_hold = 1'b1;
               else want_nb = 1'b1;
            end
            default: ;
         endcase
      end
      hold_full = want_hold && (cnt_ff >= clf_pkg::CNT_W'(clf_pkg::PENDING_DEPTH));
      err       = too_long || hold_full;
   end

   // next line state
   always_comb begin
      cnt_in   = cnt_ff;
      bsl_in   = bsl_ff;
      phase_in = phase_ff;
      has_in   = has_ff;
      len_in   = len_ff;
      if (line_end || err) begin
         cnt_in   = '0;
         bsl_in   = 1'b0;
         phase_in = err ? clf_pkg::PH_DROP : clf_pkg::PH_LEAD;
         has_in   = 1'b0;
         len_in   = '0;
      end else begin
         len_in = len_ff + clf_pkg::LEN_W'(1);
         if (drop_hash) begin
            cnt_in   = '0;
            bsl_in   = 1'b0;
            phase_in = clf_pkg::PH_DROP;
         end
         if (to_cut) phase_in = clf_pkg::PH_CUT;
         if (want_hold) cnt_in = cnt_ff + clf_pkg::CNT_W'(1);
         if (want_nb) begin
            phase_in = clf_pkg::PH_BODY;
            cnt_in   = '0;
            bsl_in   = 1'b0;
            if (bsl_ff && (cnt_ff != '0)) has_in = 1'b1;
            // a backslash is held as the lead entry, kept only in the flag
            if (chr == clf_pkg::CH_BSL) begin
               cnt_in = clf_pkg::CNT_W'(1);
               bsl_in = 1'b1;
            end else begin
               has_in = 1'b1;
            end
         end
      end
   end

   // results the item causes
   always_comb begin
      plan            = '0;
      plan.tail0_kind = clf_pkg::K_CHAR;
      plan.tail1_kind = clf_pkg::K_STREAM_END;
      if (act) begin
         plan.tail_cnt   = emit_le ? 2'd2 : 2'd1;
         plan.tail0_kind = emit_le ? clf_pkg::K_LINE_END : clf_pkg::K_STREAM_END;
      end else if (line_end) begin
         plan.tail_cnt   = emit_le ? 2'd1 : 2'd0;
         plan.tail0_kind = clf_pkg::K_LINE_END;
      end else if (err) begin
         plan.tail_cnt   = 2'd1;
         plan.tail0_kind = clf_pkg::K_OVERFLOW;
      end else if (want_nb) begin
         plan.flush_cnt = cnt_ff;
         plan.flush_bsl = bsl_ff;
         if (chr != clf_pkg::CH_BSL) begin
            plan.tail_cnt   = 2'd1;
            plan.tail0_char = chr;
         end
      end
   end

   assign mem_wr   = take && want_hold && !hold_full;
   assign mem_addr = cnt_ff[clf_pkg::ADDR_W-1:0];
   assign mem_data = chr;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= 1'b1;
         cnt_ff   <= '0;
         bsl_ff   <= 1'b0;
         phase_ff <= clf_pkg::PH_LEAD;
         has_ff   <= 1'b0;
         len_ff   <= '0;
      end else begin
         if (csr_wr_en) strip_ff <= csr_wr_data;
         if (take) begin
            cnt_ff   <= cnt_in;
            bsl_ff   <= bsl_in;
            phase_ff <= phase_in;
            has_ff   <= has_in;
            len_ff   <= len_in;
         end
      end
   end

endmodule

// ===== design/clf_emit.sv =====
// sequencer that reads held bytes back and drives the result register
module clf_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  clf_pkg::clf_plan_type      plan,
   output logic                       take_ok,
   output logic                       rd_en,
   output logic [clf_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   clf_pkg::clf_state_type    state_ff, state_in;
   clf_pkg::clf_plan_type     plan_ff, plan_in;
   logic [clf_pkg::CNT_W-1:0] ptr_ff, ptr_in, ptr_nxt;
   logic                      vld_ff;
   logic [7:0]                char_ff;
   clf_pkg::clf_kind_type     kind_ff;
   logic                      last_ff;

   logic                  slot_free, ptr_last, load, ld_last;
   clf_pkg::clf_kind_type ld_kind;
   logic [7:0]            ld_char;

   assign slot_free = !vld_ff || rsp_tready;
   assign ptr_nxt   = ptr_ff + clf_pkg::CNT_W'(1);
   assign ptr_last  = (ptr_nxt == plan_ff.flush_cnt);
   assign take_ok   = (state_ff == clf_pkg::E_IDLE) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clf_pkg::E_IDLE: begin
            if (start) begin
               if (plan.flush_cnt != '0) state_in = clf_pkg::E_READ;
               else if (plan.tail_cnt == 2'd2) state_in = clf_pkg::E_TAIL1;
            end
         end
         clf_pkg::E_READ: state_in = clf_pkg::E_FLUSH;
         clf_pkg::E_FLUSH: begin
            if (slot_free) begin
               if (!ptr_last) state_in = clf_pkg::E_READ;
               else if (plan_ff.tail_cnt != 2'd0) state_in = clf_pkg::E_TAIL0;
               else state_in = clf_pkg::E_IDLE;
            end
         end
         clf_pkg::E_TAIL0: begin
            if (slot_free) begin
               state_in = (plan_ff.tail_cnt == 2'd2) ? clf_pkg::E_TAIL1 : clf_pkg::E_IDLE;
            end
         end
         clf_pkg::E_TAIL1: begin
            if (slot_free) state_in = clf_pkg::E_IDLE;
         end
         default: state_in = clf_pkg::E_IDLE;
      endcase
   end

   always_comb begin
      plan_in = plan_ff;
      ptr_in  = ptr_ff;
      load    = 1'b0;
      ld_kind = clf_pkg::K_CHAR;
      ld_char = 8'd0;
      ld_last = 1'b0;
      rd_en   = 1'b0;
      rd_addr = ptr_ff[clf_pkg::ADDR_W-1:0];
      unique case (state_ff)
         clf_pkg::E_IDLE: begin
            if (start) begin
               plan_in = plan;
               ptr_in  = '0;
               // no held bytes: first result goes straight to the output
               if ((plan.flush_cnt == '0) && (plan.tail_cnt != 2'd0)) begin
                  load    = 1'b1;
                  ld_kind = plan.tail0_kind;
                  ld_char = plan.tail0_char;
                  ld_last = (plan.tail_cnt == 2'd1);
               end
            end
         end
         clf_pkg::E_READ: rd_en = 1'b1;
         clf_pkg::E_FLUSH: begin
            if (slot_free) begin
               load    = 1'b1;
               ld_char = ((ptr_ff == '0) && plan_ff.flush_bsl) ? clf_pkg::CH_BSL : rd_data;
               ld_last = ptr_last && (plan_ff.tail_cnt == 2'd0);
               ptr_in  = ptr_nxt;
            end
         end
         clf_pkg::E_TAIL0: begin
            if (slot_free) begin
               load    = 1'b1;
               ld_kind = plan_ff.tail0_kind;
               ld_char = plan_ff.tail0_char;
               ld_last = (plan_ff.tail_cnt == 2'd1);
            end
         end
         clf_pkg::E_TAIL1: begin
            if (slot_free) begin
               load    = 1'b1;
               ld_kind = plan_ff.tail1_kind;
               ld_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clf_pkg::E_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      ptr_ff  <= ptr_in;
      if (load) begin
         kind_ff <= ld_kind;
         char_ff <= ld_char;
         last_ff <= ld_last;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== design/comment_line_filter.sv =====
// top level of the comment line filter: line control, held-byte memory, result sequencer
//
//   port group   dir   payload (low bit up)          note
//   req_*        in    tdata: char_in  tuser: action  text bytes, end of stream
//   rsp_*        out   tdata: out_char tuser: kind    tlast marks last result of an item
//   csr_*        in    wr_data: strip_trailing_comments
//
// an item that causes no result or one result leaves the sequencer idle
// an item that releases held blanks closes the input until all its results are out, with
// one read of the held-byte memory and one output load per held byte
// reset is synchronous; the held-byte memory needs no clearing pass
// rsp_tready low with rsp_tvalid high holds the result and stops the sequencer; req_tready drops
module comment_line_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_in
   input  logic       req_tuser,   // action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char
   output logic [1:0] rsp_tuser,   // kind
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   clf_pkg::clf_plan_type      plan;
   logic                       take, take_ok;
   logic                       mem_wr, rd_en;
   logic [clf_pkg::ADDR_W-1:0] mem_addr, rd_addr;
   logic [7:0]                 mem_data, rd_data;

   assign req_tready = take_ok;
   assign take       = req_tvalid && take_ok;

   clf_line_ctl u_line (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .act         (req_tuser),
      .chr         (req_tdata),
      .plan        (plan),
      .mem_wr      (mem_wr),
      .mem_addr    (mem_addr),
      .mem_data    (mem_data)
   );

   clf_pend_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (mem_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   clf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (take),
      .plan       (plan),
      .take_ok    (take_ok),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // held-byte memory is written only by an accepted item
   a_wr_on_take: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> take)
      else $error("held-byte write without an accepted item");

   // reads back happen only while the input side is closed
   a_rd_busy: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !req_tready)
      else $error("memory read while accepting items");

   // an item with held bytes to release closes the input next cycle
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      (take && (plan.flush_cnt != '0)) |=> !req_tready)
      else $error("input open during release of held bytes");

   // never more than two results after the held bytes
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      take |-> (plan.tail_cnt != 2'd3))
      else $error("bad result count");

endmodule
